>>> src/rlfdt_pkg.sv
// Shared constants, codes and payload types for the run-length FIFO drain tally block.
`default_nettype none
package rlfdt_pkg;
   localparam int QUEUE_DEPTH     = 1024;
   localparam int COUNT_BITS      = 20;
   localparam int LETTER_COUNT    = 26;
   localparam int LETTER_BITS     = 5;
   localparam int AMOUNT_BITS     = 20;
   localparam int SUM_BITS        = 40;
   localparam int PTR_BITS        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_BITS        = $clog2(QUEUE_DEPTH + 1);
   localparam int RUN_BITS        = LETTER_BITS + COUNT_BITS;
   localparam int TALLY_BITS      = AMOUNT_BITS;
   localparam int TALLY_ADDR_BITS = $clog2(LETTER_COUNT);
   localparam int CMP_BITS        = (COUNT_BITS > AMOUNT_BITS) ? COUNT_BITS : AMOUNT_BITS;
   localparam int FACTOR_BITS     = TALLY_BITS + 1;
   localparam int PROD_BITS       = AMOUNT_BITS + FACTOR_BITS;

   localparam logic OP_PUSH     = 1'b0;
   localparam logic OP_DRAIN    = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [LETTER_BITS-1:0] letter;
      logic [AMOUNT_BITS-1:0] amount;
   } req_payload_type;

   typedef struct packed {
      logic                status;
      logic [SUM_BITS-1:0] square_sum;
   } rsp_payload_type;
endpackage
`default_nettype wire

>>> src/rlfdt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rlfdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> src/run_length_fifo_drain_tally.sv
// A push goes to S_FIN, which loads its result; a drain steps S_READ and S_RUN per
// run (plus S_TALLY, S_MUL, S_ACC if it carries units of a letter), then S_FIN.
// Throughput: one transaction at a time; the next is accepted once the result
// is loaded into the output register, which holds it while the next one runs.
// Reset clears the pointers, occupancy, tally valid bits and the result valid flag;
// the run store is not cleared.
`default_nettype none
module run_length_fifo_drain_tally
   import rlfdt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_RUN, S_TALLY, S_MUL, S_ACC, S_FIN
   } state_type;

   state_type                 state_ff, state_in;
   logic [PTR_BITS-1:0]       head_ff, head_in;
   logic [PTR_BITS-1:0]       tail_ff, tail_in;
   logic [OCC_BITS-1:0]       occ_ff, occ_in;
   logic [AMOUNT_BITS-1:0]    amt_ff, amt_in;
   logic [LETTER_BITS-1:0]    lt_ff, lt_in;
   logic [AMOUNT_BITS-1:0]    take_ff, take_in;
   logic [FACTOR_BITS-1:0]    factor_ff, factor_in;
   logic [SUM_BITS-1:0]       prod_ff, prod_in;
   logic [SUM_BITS-1:0]       sum_ff, sum_in;
   logic                      status_ff, status_in;
   logic [LETTER_COUNT-1:0]   tvalid_ff, tvalid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic                       run_we;
   logic [PTR_BITS-1:0]        run_waddr;
   logic [RUN_BITS-1:0]        run_wdata;
   logic [RUN_BITS-1:0]        run_rdata;
   logic                       tally_we;
   logic [TALLY_ADDR_BITS-1:0] tally_waddr;
   logic [TALLY_BITS-1:0]      tally_wdata;
   logic [TALLY_ADDR_BITS-1:0] tally_raddr;
   logic [TALLY_BITS-1:0]      tally_rdata;

   logic [LETTER_BITS-1:0] run_letter;
   logic [COUNT_BITS-1:0]  run_count;
   logic [CMP_BITS-1:0]    have_ext;
   logic [CMP_BITS-1:0]    amt_ext;
   logic [TALLY_BITS-1:0]  tally_cur;
   logic [PROD_BITS-1:0]   prod_full;
   logic [PTR_BITS-1:0]    head_next;
   logic [PTR_BITS-1:0]    tail_next;

   rlfdt_ram #(.WIDTH(RUN_BITS), .DEPTH(QUEUE_DEPTH)) u_run_ram (
      .clock   (clock),
      .wr_en   (run_we),
      .wr_addr (run_waddr),
      .wr_data (run_wdata),
      .rd_addr (head_ff),
      .rd_data (run_rdata)
   );

   rlfdt_ram #(.WIDTH(TALLY_BITS), .DEPTH(LETTER_COUNT)) u_tally_ram (
      .clock   (clock),
      .wr_en   (tally_we),
      .wr_addr (tally_waddr),
      .wr_data (tally_wdata),
      .rd_addr (tally_raddr),
      .rd_data (tally_rdata)
   );

   assign run_letter = run_rdata[RUN_BITS-1:COUNT_BITS];
   assign run_count  = run_rdata[COUNT_BITS-1:0];
   assign have_ext   = CMP_BITS'(run_count);
   assign amt_ext    = CMP_BITS'(amt_ff);
   assign tally_cur  = tvalid_ff[lt_ff] ? tally_rdata : '0;
   assign prod_full  = PROD_BITS'(take_ff) * PROD_BITS'(factor_ff);
   assign head_next  = (head_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next  = (tail_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      amt_in         = amt_ff;
      lt_in          = lt_ff;
      take_in        = take_ff;
      factor_in      = factor_ff;
      prod_in        = prod_ff;
      sum_in         = sum_ff;
      status_in      = status_ff;
      tvalid_in      = tvalid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      run_we         = 1'b0;
      run_waddr      = tail_ff;
      run_wdata      = {req_payload.letter, COUNT_BITS'(req_payload.amount)};
      tally_we       = 1'b0;
      tally_waddr    = TALLY_ADDR_BITS'(lt_ff);
      tally_wdata    = tally_cur + take_ff;
      tally_raddr    = TALLY_ADDR_BITS'(run_letter);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sum_in    = '0;
               status_in = STATUS_OK;
               if (req_payload.op == OP_PUSH) begin
                  if (occ_ff >= OCC_BITS'(QUEUE_DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     run_we  = 1'b1;
                     tail_in = tail_next;
                     occ_in  = occ_ff + 1'b1;
                  end
                  state_in = S_FIN;
               end else begin
                  amt_in    = req_payload.amount;
                  tvalid_in = '0;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            // head entry is read this cycle, data arrives in S_RUN
            if (amt_ff == '0 || occ_ff == '0) begin
               state_in = S_FIN;
            end else begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            lt_in = run_letter;
            if (have_ext <= amt_ext) begin
               take_in = AMOUNT_BITS'(have_ext);
               head_in = head_next;
               occ_in  = occ_ff - 1'b1;
            end else begin
               // cut the head run short and leave the remainder in place
               take_in   = amt_ff;
               run_we    = 1'b1;
               run_waddr = head_ff;
               run_wdata = {run_letter, COUNT_BITS'(have_ext - amt_ext)};
            end
            amt_in = amt_ff - take_in;
            if (run_letter < LETTER_BITS'(LETTER_COUNT) && take_in != '0) begin
               state_in = S_TALLY;
            end else begin
               state_in = S_READ;
            end
         end
         S_TALLY: begin
            // (t + k)^2 - t^2 = k * (2t + k)
            tally_we         = 1'b1;
            tvalid_in[lt_ff] = 1'b1;
            factor_in        = {tally_cur, 1'b0} + FACTOR_BITS'(take_ff);
            state_in         = S_MUL;
         end
         S_MUL: begin
            prod_in  = prod_full[SUM_BITS-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            sum_in   = sum_ff + prod_ff;
            state_in = S_READ;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.status     = status_ff;
               rsp_payload_in.square_sum = sum_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         tvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         tvalid_ff    <= tvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      amt_ff         <= amt_in;
      lt_ff          <= lt_in;
      take_ff        <= take_in;
      factor_ff      <= factor_in;
      prod_ff        <= prod_in;
      sum_ff         <= sum_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_BITS'(QUEUE_DEPTH))
      else $error("occupancy exceeds queue depth");

   a_ptr_occ: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) |-> (occ_ff == '0 || occ_ff == OCC_BITS'(QUEUE_DEPTH)))
      else $error("pointers equal with partial occupancy");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_FIN))
      else $error("result loaded outside the finish state");

   a_full_no_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.status == STATUS_FULL)
         |-> (rsp_payload_ff.square_sum == '0))
      else $error("dropped push carries a nonzero sum");
`endif
endmodule
`default_nettype wire
